/* design/bfla_pkg.sv */
package bfla_pkg;

    localparam int unsigned FIFO_DEPTH_DEF  = 256;
    localparam int unsigned LINE_LENGTH_DEF = 64;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic ST_CHAR    = 1'b0;
    localparam logic ST_NO_LINE = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_data;
    } t_item;

    typedef struct packed {
        logic       status;
        logic [7:0] line_char;
        logic       last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN_RD,
        S_DRAIN_CHK,
        S_LINE_FIRST,
        S_LINE_EMIT,
        S_LINE_TAIL
    } t_state;

endpackage

/* design/bfla_ram.sv */
module bfla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/byte_fifo_line_assembler.sv */
// Channel   Ports                      Transfer
// ------    -------------------------  -------------------------------------
// item in   start, busy, i_item        taken at an edge with start & !busy
// result    o_valid, o_result          valid-qualified, no back-pressure
//
// A push writes the FIFO RAM unless it is full. A drain reads each popped
// byte in S_DRAIN_RD and checks it in S_DRAIN_CHK (registered RAM read),
// then gives a no-line result for an empty FIFO or emits a found line.
// Synchronous reset clears pointers, line index and state; both RAMs keep
// their contents and need no clearing pass. start is ignored while busy is
// high; the receiver cannot stall results.
module byte_fifo_line_assembler
    import bfla_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH  = FIFO_DEPTH_DEF,
    parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    localparam int unsigned FW = $clog2(FIFO_DEPTH);
    localparam int unsigned LW = $clog2(LINE_LENGTH);

    t_state r_state, n_state;
    logic [FW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_bound, n_bound;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_char, n_char;

    logic [FW-1:0] wp_inc, rp_inc;
    logic          full;
    logic          accept;
    logic          fifo_we;
    logic [7:0]    fifo_rdata;
    logic          line_we;
    logic [7:0]    line_rdata;
    logic [LW:0]   cnt_inc;

    assign wp_inc  = (r_wp == FW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_inc  = (r_rp == FW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign full    = (wp_inc == r_rp);
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign fifo_we = accept && (i_item.operation == OP_PUSH) && !full;
    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    bfla_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (r_wp),
        .i_wdata (i_item.rx_data),
        .i_raddr (r_rp),
        .o_rdata (fifo_rdata)
    );

    bfla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LENGTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_idx),
        .i_wdata (fifo_rdata),
        .i_raddr (n_cnt),
        .o_rdata (line_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_cnt   <= n_cnt;
        r_char  <= n_char;
    end

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_idx    = r_idx;
        n_bound  = r_bound;
        n_cnt    = r_cnt;
        n_char   = r_char;
        line_we  = 1'b0;
        o_valid  = 1'b0;
        o_result = '{status: ST_CHAR, line_char: r_char, last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.operation == OP_DRAIN) begin
                        n_state = S_DRAIN_RD;
                    end else if (!full) begin
                        n_wp = wp_inc;
                    end
                end
            end
            S_DRAIN_RD: begin
                if (r_rp == r_wp) begin
                    o_valid  = 1'b1;
                    o_result = '{status: ST_NO_LINE, line_char: 8'h00, last: 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_rp    = rp_inc;
                    n_state = S_DRAIN_CHK;
                end
            end
            S_DRAIN_CHK: begin
                n_state = S_DRAIN_RD;
                if (fifo_rdata == CH_LF) begin
                    n_idx = '0;
                    if (r_idx != '0) begin
                        n_bound = r_idx;
                        n_cnt   = '0;
                        n_state = S_LINE_FIRST;
                    end
                end else if (fifo_rdata != CH_CR) begin
                    if (r_idx == LW'(LINE_LENGTH - 1)) begin
                        n_idx = '0;
                    end else begin
                        line_we = 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            S_LINE_FIRST: begin
                if (line_rdata == 8'h00) begin
                    n_state = S_DRAIN_RD;
                end else if (r_bound == LW'(1)) begin
                    o_valid  = 1'b1;
                    o_result = '{status: ST_CHAR, line_char: line_rdata, last: 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_char  = line_rdata;
                    n_cnt   = LW'(1);
                    n_state = S_LINE_EMIT;
                end
            end
            S_LINE_EMIT: begin
                o_valid = 1'b1;
                if (line_rdata == 8'h00) begin
                    o_result.last = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_char = line_rdata;
                    if (cnt_inc == {1'b0, r_bound}) begin
                        n_state = S_LINE_TAIL;
                    end else begin
                        n_cnt = cnt_inc[LW-1:0];
                    end
                end
            end
            S_LINE_TAIL: begin
                o_valid       = 1'b1;
                o_result.last = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result outside a drain");

    a_no_line_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NO_LINE) |-> o_result.last)
        else $error("no-line result without last");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !busy)
        else $error("drain continues after last result");

    a_full_push_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.operation == OP_PUSH && full) |=> $stable(r_wp))
        else $error("push into full FIFO moved write pointer");

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_CHK) |-> ($past(r_state) == S_DRAIN_RD))
        else $error("FIFO data checked without a read");

endmodule
